/* rtl/rsum_pkg.sv */
package rsum_pkg;

  // Array geometry
  localparam int ARRAY_DEPTH = 1024;
  localparam int BLOCK_COUNT = 64;
  localparam int ELEM_AW     = $clog2(ARRAY_DEPTH);
  localparam int BLK_AW      = $clog2(BLOCK_COUNT);
  localparam int IDX_W       = ELEM_AW + 1;

  // Field and storage widths
  localparam int LEN_W  = 11;
  localparam int ELEM_W = 32;
  localparam int BSUM_W = 42;
  localparam int SUM_W  = 64;

  // Block length limits
  localparam int LEN_CEIL  = (ARRAY_DEPTH + BLOCK_COUNT - 1) / BLOCK_COUNT;
  localparam int LEN_FLOOR = (LEN_CEIL > 16) ? LEN_CEIL : 16;
  localparam int LEN_RESET = 32;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [ELEM_AW-1:0] eaddr_t;
  typedef logic [BLK_AW-1:0]  baddr_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [3:0] {
    ST_CLR_ELEM,
    ST_CLR_BLK,
    ST_WALK,
    ST_WALK_END,
    ST_IDLE,
    ST_DIV,
    ST_WR_RD,
    ST_WR_UPD,
    ST_Q_PART1,
    ST_Q_BLK,
    ST_Q_PART2,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic   done;
    eaddr_t quot;
    len_t   rem;
  } div_res_t;

  function automatic baddr_t sat_blk(input eaddr_t q);
    if (q >= ELEM_AW'(BLOCK_COUNT)) return BLK_AW'(BLOCK_COUNT - 1);
    else return q[BLK_AW-1:0];
  endfunction

  function automatic baddr_t inc_blk(input baddr_t b);
    if (b == BLK_AW'(BLOCK_COUNT - 1)) return b;
    else return b + 1'b1;
  endfunction

  function automatic logic signed [SUM_W-1:0] sext_elem(input logic [ELEM_W-1:0] v);
    return {{(SUM_W - ELEM_W){v[ELEM_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] sext_bsum(input logic [BSUM_W-1:0] v);
    return {{(SUM_W - BSUM_W){v[BSUM_W-1]}}, v};
  endfunction

endpackage

/* rtl/rsum_if.sv */
interface rsum_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [9:0]  left_index;
  logic [9:0]  right_index;
  logic signed [31:0] write_value;

  modport source (output valid, mode, left_index, right_index, write_value, input ready);
  modport sink   (input valid, mode, left_index, right_index, write_value, output ready);
endinterface

interface rsum_out_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

/* rtl/block_range_sum_store.sv */
// Block range-sum store: 1024 signed 32-bit elements plus one 42-bit running
// sum per block of block_length elements (values below 16 are taken as 16).
// A write beat (mode 0) replaces one element and corrects its block sum; it
// gives no result and first finds the element's block in the serial divider
// (one quotient bit per cycle). A query beat (mode 1) returns the 64-bit sum
// of elements left_index..right_index, 0 when left > right. A query reads
// each element of the partial blocks at either end and the block sum of each
// whole block in between, one read at a time, because all reads go through
// the single read port of each store. After reset the block clears the
// element store, then the block sums, then runs a rebuild, all with
// in_ch.ready low. A write to cfg_we rebuilds every block sum from the
// elements under the new length; no beat is accepted during the rebuild. A
// finished result sits in an output register, so the next beat is accepted
// while it waits.
module block_range_sum_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [10:0]           cfg_data,
  rsum_in_if.sink               in_ch,
  rsum_out_if.source            out_ch
);

  // FSM and walk state
  rsum_pkg::state_t state_r, state_nxt;
  rsum_pkg::idx_t   idx_r, idx_nxt;     // element index / sweep counter
  rsum_pkg::len_t   off_r, off_nxt;     // offset inside current block
  rsum_pkg::baddr_t blk_r, blk_nxt;     // current block
  rsum_pkg::len_t   len_r, len_nxt;     // effective block length
  logic             pend_r, pend_nxt;   // rebuild requested

  // latched beat
  logic                          mode_r, mode_nxt;
  logic [rsum_pkg::ELEM_AW-1:0]  right_r, right_nxt;
  logic [rsum_pkg::ELEM_W-1:0]   val_r, val_nxt;

  // accumulate stage (registered from the read issue, works on it in the cycle after)
  logic signed [rsum_pkg::SUM_W-1:0] acc_r, acc_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_src_r, rd_src_nxt;   // 1: block sum, 0: element
  logic             rd_wb_r, rd_wb_nxt;     // rebuild: close out block
  rsum_pkg::baddr_t rd_blk_r, rd_blk_nxt;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [rsum_pkg::SUM_W-1:0] out_sum_r, out_sum_nxt;

  // store ports
  logic                          elem_we;
  rsum_pkg::eaddr_t              elem_waddr;
  logic [rsum_pkg::ELEM_W-1:0]   elem_wdata, elem_rdata;
  logic                          blk_we;
  rsum_pkg::baddr_t              blk_waddr;
  logic [rsum_pkg::BSUM_W-1:0]   blk_wdata, blk_rdata;

  logic                 div_start;
  rsum_pkg::div_res_t   div_res;

  logic go_rebuild, in_acc, out_free, restart;
  logic walk_last, p1_go, blk_go, p2_go;
  logic issue, iss_src, iss_wb;
  logic signed [rsum_pkg::SUM_W-1:0] addend, acc_sum;
  logic [rsum_pkg::BSUM_W-1:0] wr_bsum;

  assign go_rebuild = cfg_we || pend_r;
  assign in_ch.ready = (state_r == rsum_pkg::ST_IDLE) && !go_rebuild;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.range_sum = out_sum_r;

  // loop conditions
  assign walk_last = (off_r == len_r - 1'b1) ||
                     (idx_r == rsum_pkg::IDX_W'(rsum_pkg::ARRAY_DEPTH - 1));
  assign p1_go  = (idx_r <= {1'b0, right_r}) && (off_r != '0);
  assign blk_go = ({1'b0, idx_r} + {1'b0, len_r}) <= {2'b00, right_r} + 12'd1;
  assign p2_go  = (idx_r <= {1'b0, right_r});

  // write beat: new block sum = old + new element - old element
  assign wr_bsum = blk_rdata + rsum_pkg::BSUM_W'(rsum_pkg::sext_elem(val_r))
                   - rsum_pkg::BSUM_W'(rsum_pkg::sext_elem(elem_rdata));

  assign addend  = rd_src_r ? rsum_pkg::sext_bsum(blk_rdata)
                            : rsum_pkg::sext_elem(elem_rdata);
  assign acc_sum = acc_r + addend;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsum_pkg::ST_CLR_ELEM: begin
        if (idx_r == rsum_pkg::IDX_W'(rsum_pkg::ARRAY_DEPTH - 1)) begin
          state_nxt = rsum_pkg::ST_CLR_BLK;
        end
      end
      rsum_pkg::ST_CLR_BLK: begin
        if (!go_rebuild && idx_r == rsum_pkg::IDX_W'(rsum_pkg::BLOCK_COUNT - 1)) begin
          state_nxt = rsum_pkg::ST_WALK;
        end
      end
      rsum_pkg::ST_WALK: begin
        if (go_rebuild) begin
          state_nxt = rsum_pkg::ST_CLR_BLK;
        end else if (idx_r == rsum_pkg::IDX_W'(rsum_pkg::ARRAY_DEPTH - 1)) begin
          state_nxt = rsum_pkg::ST_WALK_END;
        end
      end
      rsum_pkg::ST_WALK_END: begin
        state_nxt = go_rebuild ? rsum_pkg::ST_CLR_BLK : rsum_pkg::ST_IDLE;
      end
      rsum_pkg::ST_IDLE: begin
        if (go_rebuild) begin
          state_nxt = rsum_pkg::ST_CLR_BLK;
        end else if (in_acc) begin
          if (in_ch.mode == rsum_pkg::MODE_QUERY &&
              in_ch.left_index > in_ch.right_index) begin
            state_nxt = rsum_pkg::ST_Q_DONE;
          end else begin
            state_nxt = rsum_pkg::ST_DIV;
          end
        end
      end
      rsum_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_nxt = (mode_r == rsum_pkg::MODE_QUERY) ? rsum_pkg::ST_Q_PART1
                                                       : rsum_pkg::ST_WR_RD;
        end
      end
      rsum_pkg::ST_WR_RD:   state_nxt = rsum_pkg::ST_WR_UPD;
      rsum_pkg::ST_WR_UPD:  state_nxt = rsum_pkg::ST_IDLE;
      rsum_pkg::ST_Q_PART1: if (!p1_go) state_nxt = rsum_pkg::ST_Q_BLK;
      rsum_pkg::ST_Q_BLK:   if (!blk_go) state_nxt = rsum_pkg::ST_Q_PART2;
      rsum_pkg::ST_Q_PART2: if (!p2_go) state_nxt = rsum_pkg::ST_Q_DONE;
      rsum_pkg::ST_Q_DONE:  if (out_free) state_nxt = rsum_pkg::ST_IDLE;
    endcase
  end

  assign restart = (state_nxt == rsum_pkg::ST_CLR_BLK) &&
                   ((state_r != rsum_pkg::ST_CLR_BLK) || go_rebuild);

  // datapath and store control
  always_comb begin
    idx_nxt    = idx_r;
    off_nxt    = off_r;
    blk_nxt    = blk_r;
    pend_nxt   = pend_r || cfg_we;
    len_nxt    = len_r;
    mode_nxt   = mode_r;
    right_nxt  = right_r;
    val_nxt    = val_r;
    acc_nxt    = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sum_nxt   = out_sum_r;

    elem_we    = 1'b0;
    elem_waddr = idx_r[rsum_pkg::ELEM_AW-1:0];
    elem_wdata = '0;
    blk_we     = 1'b0;
    blk_waddr  = idx_r[rsum_pkg::BLK_AW-1:0];
    blk_wdata  = '0;
    issue      = 1'b0;
    iss_src    = 1'b0;
    iss_wb     = 1'b0;
    div_start  = 1'b0;

    if (cfg_we) begin
      len_nxt = (cfg_data < rsum_pkg::LEN_W'(rsum_pkg::LEN_FLOOR))
                ? rsum_pkg::LEN_W'(rsum_pkg::LEN_FLOOR) : cfg_data;
    end

    unique case (state_r)
      rsum_pkg::ST_CLR_ELEM: begin
        elem_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      rsum_pkg::ST_CLR_BLK: begin
        blk_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        acc_nxt = '0;
      end
      rsum_pkg::ST_WALK: begin
        issue   = 1'b1;
        iss_wb  = walk_last;
        idx_nxt = idx_r + 1'b1;
        if (off_r == len_r - 1'b1) begin
          off_nxt = '0;
          blk_nxt = rsum_pkg::inc_blk(blk_r);
        end else begin
          off_nxt = off_r + 1'b1;
        end
      end
      rsum_pkg::ST_WALK_END: begin
      end
      rsum_pkg::ST_IDLE: begin
        if (in_acc) begin
          div_start = 1'b1;
          idx_nxt   = {1'b0, in_ch.left_index};
          mode_nxt  = in_ch.mode;
          right_nxt = in_ch.right_index;
          val_nxt   = in_ch.write_value;
          acc_nxt   = '0;
        end
      end
      rsum_pkg::ST_DIV: begin
        if (div_res.done) begin
          off_nxt = div_res.rem;
          blk_nxt = rsum_pkg::sat_blk(div_res.quot);
        end
      end
      rsum_pkg::ST_WR_RD: begin
        // reads of idx_r / blk_r land next cycle
      end
      rsum_pkg::ST_WR_UPD: begin
        elem_we    = 1'b1;
        elem_wdata = val_r;
        blk_we     = 1'b1;
        blk_waddr  = blk_r;
        blk_wdata  = wr_bsum;
      end
      rsum_pkg::ST_Q_PART1: begin
        if (p1_go) begin
          issue   = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (off_r == len_r - 1'b1) begin
            off_nxt = '0;
            blk_nxt = rsum_pkg::inc_blk(blk_r);
          end else begin
            off_nxt = off_r + 1'b1;
          end
        end
      end
      rsum_pkg::ST_Q_BLK: begin
        if (blk_go) begin
          issue   = 1'b1;
          iss_src = 1'b1;
          idx_nxt = rsum_pkg::IDX_W'(idx_r + len_r);
          blk_nxt = rsum_pkg::inc_blk(blk_r);
        end
      end
      rsum_pkg::ST_Q_PART2: begin
        if (p2_go) begin
          issue   = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      rsum_pkg::ST_Q_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
        end
      end
    endcase

    // leaving the clear pass into the walk
    if (state_r == rsum_pkg::ST_CLR_BLK && state_nxt == rsum_pkg::ST_WALK) begin
      idx_nxt = '0;
      off_nxt = '0;
      blk_nxt = '0;
    end

    if (restart) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
    end

    // accumulate stage; data in flight at a rebuild restart is dropped
    rd_vld_nxt = issue;
    rd_src_nxt = iss_src;
    rd_wb_nxt  = iss_wb;
    rd_blk_nxt = blk_r;
    if (rd_vld_r && state_r != rsum_pkg::ST_CLR_BLK) begin
      acc_nxt = acc_sum;
      if (rd_wb_r) begin
        blk_we    = 1'b1;
        blk_waddr = rd_blk_r;
        blk_wdata = acc_sum[rsum_pkg::BSUM_W-1:0];
        acc_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsum_pkg::ST_CLR_ELEM;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      len_r       <= rsum_pkg::LEN_W'(rsum_pkg::LEN_RESET);
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      len_r       <= len_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    off_r     <= off_nxt;
    blk_r     <= blk_nxt;
    mode_r    <= mode_nxt;
    right_r   <= right_nxt;
    val_r     <= val_nxt;
    acc_r     <= acc_nxt;
    rd_src_r  <= rd_src_nxt;
    rd_wb_r   <= rd_wb_nxt;
    rd_blk_r  <= rd_blk_nxt;
    out_sum_r <= out_sum_nxt;
  end

  // element store
  rsum_ram #(
    .DEPTH (rsum_pkg::ARRAY_DEPTH),
    .WIDTH (rsum_pkg::ELEM_W)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (idx_r[rsum_pkg::ELEM_AW-1:0]),
    .rdata (elem_rdata)
  );

  // block sum table
  rsum_ram #(
    .DEPTH (rsum_pkg::BLOCK_COUNT),
    .WIDTH (rsum_pkg::BSUM_W)
  ) u_bsum_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_r),
    .rdata (blk_rdata)
  );

  // block index and offset of left_index
  rsum_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_ch.left_index),
    .divisor  (len_r),
    .res      (div_res)
  );

endmodule

/* rtl/rsum_ram.sv */
module rsum_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rsum_div.sv */
// Restoring divider, one quotient bit per cycle.
module rsum_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rsum_pkg::eaddr_t    dividend,
  input  rsum_pkg::len_t      divisor,
  output rsum_pkg::div_res_t  res
);

  localparam int CNT_W = $clog2(rsum_pkg::ELEM_AW + 1);

  rsum_pkg::eaddr_t q_r, q_nxt;
  rsum_pkg::len_t   rem_r, rem_nxt;
  rsum_pkg::len_t   d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [rsum_pkg::LEN_W:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[rsum_pkg::ELEM_AW-1]};
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      d_nxt   = divisor;
      cnt_nxt = CNT_W'(rsum_pkg::ELEM_AW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = rsum_pkg::LEN_W'(trial - {1'b0, d_r});
        q_nxt   = {q_r[rsum_pkg::ELEM_AW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[rsum_pkg::LEN_W-1:0];
        q_nxt   = {q_r[rsum_pkg::ELEM_AW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rem  = rem_r;

endmodule
